// ===== hdl/bdpc_pkg.sv =====
package bdpc_pkg;

    // Fixed field widths of the pixel transaction.
    localparam int PIX_W      = 12;
    localparam int POS_W      = 22;
    localparam int RAD_W      = 20;
    localparam int ALPHA_W    = 9;
    localparam int BYTE_W     = 8;
    localparam int SIDE_REG_W = 13;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Signed width used for the bounding box edges before clamping.
    localparam int BOX_W = 24;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 9'd256;
    localparam logic [BYTE_W-1:0]  BYTE_MAX     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH  = 3'd0,
        CFG_CANVAS_HEIGHT = 3'd1,
        CFG_BRUSH_RED     = 3'd2,
        CFG_BRUSH_GREEN   = 3'd3,
        CFG_BRUSH_BLUE    = 3'd4
    } t_cfg_index;

    // Per-pixel values that ride alongside the root extraction.
    typedef struct packed {
        logic               in_box;
        logic [RAD_W-1:0]   radius;
        logic [ALPHA_W-1:0] alpha;
        logic [BYTE_W-1:0]  old_alpha;
    } t_side;

endpackage

// ===== hdl/bdpc_sqrt_pipe.sv =====
module bdpc_sqrt_pipe
    import bdpc_pkg::*;
#(
    parameter int ROOT_W = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output t_side                 o_side
);

    localparam int IN_W  = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    // One result bit is settled per stage, most significant first.
    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [IN_W-1:0]   r_rest [ROOT_W];
    t_side             r_side [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic              stg_vld;
            logic [REM_W-1:0]  stg_rem;
            logic [ROOT_W-1:0] stg_root;
            logic [IN_W-1:0]   stg_rest;
            t_side             stg_side;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;
            logic [REM_W-1:0]  n_rem;
            logic [ROOT_W-1:0] n_root;
            logic [IN_W-1:0]   n_rest;

            if (k == 0) begin : g_first
                assign stg_vld  = i_valid;
                assign stg_rem  = '0;
                assign stg_root = '0;
                assign stg_rest = i_radicand;
                assign stg_side = i_side;
            end else begin : g_next
                assign stg_vld  = r_vld[k-1];
                assign stg_rem  = r_rem[k-1];
                assign stg_root = r_root[k-1];
                assign stg_rest = r_rest[k-1];
                assign stg_side = r_side[k-1];
            end

            always_comb begin
                rem_sh = {stg_rem[REM_W-3:0], stg_rest[IN_W-1 -: 2]};
                trial  = {stg_root, 2'b01};
                take   = (rem_sh >= trial);
                n_rem  = take ? (rem_sh - trial) : rem_sh;
                n_root = {stg_root[ROOT_W-2:0], take};
                n_rest = {stg_rest[IN_W-3:0], 2'b00};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= stg_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rest[k] <= n_rest;
                r_side[k] <= stg_side;
            end
        end
    endgenerate

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

// ===== hdl/brush_dab_pixel_coverage.sv =====
// Round brush dab coverage for one canvas pixel per transaction.
//
// Input channel: a pixel transaction (pixel column and row, dab centre and
// radius in fixed point, dab opacity and the pixel's stored alpha) is taken
// at a rising edge where start is high and busy is low. Busy is only high
// while reset is held, so a new transaction can be issued on every cycle.
// Output channel: each transaction produces exactly one result, shown on the
// result ports for one cycle with o_valid high. The receiver has no way to
// hold results back, and none is needed because nothing here ever waits.
// Configuration: canvas size and brush colour are written through a simple
// indexed write port. The user must write them only while no transaction
// is in flight; the block does not enforce this. Pipeline: stages A, B, C,
// the fixed-point square root, then stages D, E and F. The root is ROOT_W
// bits wide (23 with 8 fraction bits) and retires one result bit per
// pipeline stage, setting its depth. Throughput is one transaction per cycle.
// Reset clears every valid bit of the pipeline, so in-flight transactions are
// dropped, and restores a 1024 by 1024 canvas and a black brush.
module brush_dab_pixel_coverage
    import bdpc_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int MAX_SIDE  = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [PIX_W-1:0]          i_pixel_col,
    input  logic [PIX_W-1:0]          i_pixel_row,
    input  logic signed [POS_W-1:0]   i_centre_x,
    input  logic signed [POS_W-1:0]   i_centre_y,
    input  logic [RAD_W-1:0]          i_dab_radius,
    input  logic [ALPHA_W-1:0]        i_dab_alpha,
    input  logic [BYTE_W-1:0]         i_old_alpha,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    output logic                      o_pixel_written,
    output logic [BYTE_W-1:0]         o_new_alpha,
    output logic [BYTE_W-1:0]         o_out_red,
    output logic [BYTE_W-1:0]         o_out_green,
    output logic [BYTE_W-1:0]         o_out_blue
);

    // Pixel centre position in fixed point, before the centre is subtracted.
    localparam int IPOS_W   = PIX_W + FRAC_BITS;
    // Magnitude of the offset to the dab centre fits in MAG_W bits.
    localparam int MAG_W    = ((IPOS_W > POS_W - 1) ? IPOS_W : POS_W - 1) + 1;
    localparam int DX_W     = MAG_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    // The root of a sum of two squares needs one bit more than each side.
    localparam int ROOT_W   = MAG_W + 1;
    localparam int RADIC_W  = 2 * ROOT_W;
    localparam int DR_W     = ((ROOT_W > RAD_W) ? ROOT_W : RAD_W) + 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int CMP_W    = ((PIX_W > SIDE_W) ? PIX_W : SIDE_W) + 1;
    localparam int PROD_W   = ALPHA_W + FRAC_BITS;
    localparam int RESET_SIDE = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;

    localparam logic [IPOS_W-1:0]       HALF_POS = IPOS_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [BOX_W-1:0] CEIL_ADD = BOX_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [DR_W-1:0]  HALF_DR  = DR_W'(1 << (FRAC_BITS - 1));

    // ------------------------------------------------------------------
    // Configuration registers. Canvas sides are stored already limited to
    // the supported range, which gives the same box as limiting at use.
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] r_side_w;
    logic [SIDE_W-1:0] r_side_h;
    logic [BYTE_W-1:0] r_red;
    logic [BYTE_W-1:0] r_green;
    logic [BYTE_W-1:0] r_blue;

    function automatic logic [SIDE_W-1:0] limit_side(input logic [SIDE_REG_W-1:0] v);
        int unsigned s;
        s = v;
        if (s < 2) begin
            s = 2;
        end
        if (s > MAX_SIDE) begin
            s = MAX_SIDE;
        end
        return SIDE_W'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_w <= SIDE_W'(RESET_SIDE);
            r_side_h <= SIDE_W'(RESET_SIDE);
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CANVAS_WIDTH:  r_side_w <= limit_side(i_cfg_data[SIDE_REG_W-1:0]);
                CFG_CANVAS_HEIGHT: r_side_h <= limit_side(i_cfg_data[SIDE_REG_W-1:0]);
                CFG_BRUSH_RED:     r_red    <= i_cfg_data[BYTE_W-1:0];
                CFG_BRUSH_GREEN:   r_green  <= i_cfg_data[BYTE_W-1:0];
                CFG_BRUSH_BLUE:    r_blue   <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline never stalls, so the only time a transaction is refused
    // is while reset is held.
    assign busy = ~i_rst_n;

    logic in_take;
    assign in_take = start & ~busy;

    // ------------------------------------------------------------------
    // Stage A: offsets from the pixel centre to the dab centre, and the raw
    // box edges floor(c - r) and ceil(c + r) in whole pixels.
    // ------------------------------------------------------------------
    function automatic logic [MAG_W-1:0] centre_offset(input logic [PIX_W-1:0] p,
                                                       input logic signed [POS_W-1:0] c);
        logic [IPOS_W-1:0]      ppos;
        logic signed [DX_W-1:0] d;
        ppos = {p, {FRAC_BITS{1'b0}}} + HALF_POS;
        d = $signed({{(DX_W - IPOS_W){1'b0}}, ppos})
            - $signed({{(DX_W - POS_W){c[POS_W-1]}}, c});
        if (d[DX_W-1]) begin
            d = -d;
        end
        return d[MAG_W-1:0];
    endfunction

    function automatic logic signed [BOX_W-1:0] edge_lo(input logic signed [POS_W-1:0] c,
                                                       input logic [RAD_W-1:0] r);
        logic signed [BOX_W-1:0] v;
        v = $signed({{(BOX_W - POS_W){c[POS_W-1]}}, c})
            - $signed({{(BOX_W - RAD_W){1'b0}}, r});
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [BOX_W-1:0] edge_hi(input logic signed [POS_W-1:0] c,
                                                       input logic [RAD_W-1:0] r);
        logic signed [BOX_W-1:0] v;
        v = $signed({{(BOX_W - POS_W){c[POS_W-1]}}, c})
            + $signed({{(BOX_W - RAD_W){1'b0}}, r}) + CEIL_ADD;
        return v >>> FRAC_BITS;
    endfunction

    logic                    r_a_vld;
    logic [MAG_W-1:0]        r_a_ux;
    logic [MAG_W-1:0]        r_a_uy;
    logic signed [BOX_W-1:0] r_a_lo_x;
    logic signed [BOX_W-1:0] r_a_hi_x;
    logic signed [BOX_W-1:0] r_a_lo_y;
    logic signed [BOX_W-1:0] r_a_hi_y;
    logic [PIX_W-1:0]        r_a_col;
    logic [PIX_W-1:0]        r_a_row;
    t_side                   r_a_side;
    t_side                   n_a_side;

    always_comb begin
        n_a_side.in_box    = 1'b0;
        n_a_side.radius    = i_dab_radius;
        n_a_side.alpha     = (i_dab_alpha > ALPHA_OPAQUE) ? ALPHA_OPAQUE : i_dab_alpha;
        n_a_side.old_alpha = i_old_alpha;
    end

    always_ff @(posedge i_clk) begin
        r_a_ux   <= centre_offset(i_pixel_col, i_centre_x);
        r_a_uy   <= centre_offset(i_pixel_row, i_centre_y);
        r_a_lo_x <= edge_lo(i_centre_x, i_dab_radius);
        r_a_hi_x <= edge_hi(i_centre_x, i_dab_radius);
        r_a_lo_y <= edge_lo(i_centre_y, i_dab_radius);
        r_a_hi_y <= edge_hi(i_centre_y, i_dab_radius);
        r_a_col  <= i_pixel_col;
        r_a_row  <= i_pixel_row;
        r_a_side <= n_a_side;
    end

    // ------------------------------------------------------------------
    // Stage B: squares of the offsets, and the box edges clamped to the
    // canvas. The exclusive upper edge is at most the last row or column.
    // ------------------------------------------------------------------
    function automatic logic [SIDE_W-1:0] clamp_lo(input logic signed [BOX_W-1:0] f,
                                                  input logic [SIDE_W-1:0] w);
        logic signed [BOX_W-1:0] ws;
        logic [SIDE_W-1:0]       res;
        ws = $signed({{(BOX_W - SIDE_W){1'b0}}, w});
        if (f < $signed(BOX_W'(1))) begin
            res = '0;
        end else if (f >= ws) begin
            res = w - SIDE_W'(1);
        end else begin
            res = f[SIDE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_hi(input logic signed [BOX_W-1:0] c,
                                                  input logic [SIDE_W-1:0] w);
        logic signed [BOX_W-1:0] ws;
        logic [SIDE_W-1:0]       res;
        ws = $signed({{(BOX_W - SIDE_W){1'b0}}, w});
        if (c <= $signed(BOX_W'(0))) begin
            res = '0;
        end else if (c > ws - $signed(BOX_W'(2))) begin
            res = w - SIDE_W'(1);
        end else begin
            res = c[SIDE_W-1:0];
        end
        return res;
    endfunction

    logic              r_b_vld;
    logic [SQ_W-1:0]   r_b_sq_x;
    logic [SQ_W-1:0]   r_b_sq_y;
    logic [SIDE_W-1:0] r_b_lo_x;
    logic [SIDE_W-1:0] r_b_hi_x;
    logic [SIDE_W-1:0] r_b_lo_y;
    logic [SIDE_W-1:0] r_b_hi_y;
    logic [PIX_W-1:0]  r_b_col;
    logic [PIX_W-1:0]  r_b_row;
    t_side             r_b_side;

    always_ff @(posedge i_clk) begin
        r_b_sq_x <= r_a_ux * r_a_ux;
        r_b_sq_y <= r_a_uy * r_a_uy;
        r_b_lo_x <= clamp_lo(r_a_lo_x, r_side_w);
        r_b_hi_x <= clamp_hi(r_a_hi_x, r_side_w);
        r_b_lo_y <= clamp_lo(r_a_lo_y, r_side_h);
        r_b_hi_y <= clamp_hi(r_a_hi_y, r_side_h);
        r_b_col  <= r_a_col;
        r_b_row  <= r_a_row;
        r_b_side <= r_a_side;
    end

    // ------------------------------------------------------------------
    // Stage C: squared distance, and the test of the pixel against the box.
    // ------------------------------------------------------------------
    logic               r_c_vld;
    logic [RADIC_W-1:0] r_c_radicand;
    t_side              r_c_side;
    logic [CMP_W-1:0]   col_c;
    logic [CMP_W-1:0]   row_c;
    t_side              n_c_side;

    always_comb begin
        col_c = CMP_W'(r_b_col);
        row_c = CMP_W'(r_b_row);
        n_c_side = r_b_side;
        n_c_side.in_box = (col_c >= CMP_W'(r_b_lo_x)) && (col_c < CMP_W'(r_b_hi_x))
                       && (row_c >= CMP_W'(r_b_lo_y)) && (row_c < CMP_W'(r_b_hi_y));
    end

    always_ff @(posedge i_clk) begin
        r_c_radicand <= RADIC_W'(r_b_sq_x) + RADIC_W'(r_b_sq_y);
        r_c_side     <= n_c_side;
    end

    // ------------------------------------------------------------------
    // Root extraction, one bit per stage.
    // ------------------------------------------------------------------
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    bdpc_sqrt_pipe #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_c_vld),
        .i_radicand (r_c_radicand),
        .i_side     (r_c_side),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage D: distance past the rim, dr = root - radius. The pixel is
    // written below half a pixel; on the soft rim the coverage factor is
    // one half minus dr, which then lies strictly between 0 and 1.
    // ------------------------------------------------------------------
    logic                   r_d_vld;
    logic                   r_d_written;
    logic                   r_d_rim;
    logic [FRAC_BITS-1:0]   r_d_diff;
    logic [ALPHA_W-1:0]     r_d_alpha;
    logic [BYTE_W-1:0]      r_d_old;
    logic signed [DR_W-1:0] dr;
    logic signed [DR_W-1:0] diff_full;

    always_comb begin
        dr = $signed(DR_W'(sq_root)) - $signed(DR_W'(sq_side.radius));
        diff_full = HALF_DR - dr;
    end

    always_ff @(posedge i_clk) begin
        r_d_written <= sq_side.in_box && (dr < HALF_DR);
        r_d_rim     <= (dr > -HALF_DR);
        r_d_diff    <= diff_full[FRAC_BITS-1:0];
        r_d_alpha   <= sq_side.alpha;
        r_d_old     <= sq_side.old_alpha;
    end

    // ------------------------------------------------------------------
    // Stage E: coverage byte, truncated and saturated.
    // ------------------------------------------------------------------
    logic               r_e_vld;
    logic               r_e_written;
    logic [BYTE_W-1:0]  r_e_cov;
    logic [BYTE_W-1:0]  r_e_old;
    logic [PROD_W-1:0]  prod;
    logic [ALPHA_W-1:0] cov_wide;

    always_comb begin
        prod     = PROD_W'(r_d_alpha) * PROD_W'(r_d_diff);
        cov_wide = r_d_rim ? prod[PROD_W-1:FRAC_BITS] : r_d_alpha;
    end

    always_ff @(posedge i_clk) begin
        r_e_written <= r_d_written;
        r_e_cov     <= (cov_wide > ALPHA_W'(BYTE_MAX)) ? BYTE_MAX : cov_wide[BYTE_W-1:0];
        r_e_old     <= r_d_old;
    end

    // ------------------------------------------------------------------
    // Stage F: output register. If written, new alpha is max of old and new.
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic              r_out_written;
    logic [BYTE_W-1:0] r_out_alpha;
    logic [BYTE_W-1:0] r_out_red;
    logic [BYTE_W-1:0] r_out_green;
    logic [BYTE_W-1:0] r_out_blue;

    always_ff @(posedge i_clk) begin
        r_out_written <= r_e_written;
        r_out_alpha   <= (r_e_written && (r_e_cov > r_e_old)) ? r_e_cov : r_e_old;
        r_out_red     <= r_e_written ? r_red   : '0;
        r_out_green   <= r_e_written ? r_green : '0;
        r_out_blue    <= r_e_written ? r_blue  : '0;
    end

    // Valid bits of the stages around the root extraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld   <= in_take;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= sq_vld;
            r_e_vld   <= r_d_vld;
            r_out_vld <= r_e_vld;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_pixel_written = r_out_written;
    assign o_new_alpha     = r_out_alpha;
    assign o_out_red       = r_out_red;
    assign o_out_green     = r_out_green;
    assign o_out_blue      = r_out_blue;

endmodule

// ===== verif/tb_brush_dab_pixel_coverage.sv =====
`timescale 1ns / 100ps

module tb_brush_dab_pixel_coverage
    import bdpc_pkg::*;
();

    // Fixed-point format of the block as instantiated.
    localparam int     FRAC       = 8;
    localparam longint HALF       = 1 << (FRAC - 1);
    localparam longint CANVAS_MAX = 4096;

    // The final drain waits longer than the pipeline depth so that a stray
    // strobe after the last expected result is still caught.
    localparam int DRAIN_CYCLES = 40;

    // The slowest correct run is about 775 transactions with random idle
    // gaps, plus configuration and drains. The limit is taken many times
    // over what that run needs.
    localparam int CYCLE_LIMIT = 200000;

    // Index 7 decodes to no register, so a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 3'd7;

    // One pixel transaction as presented on the input ports. Centre fields
    // hold raw two's complement bits and are sign extended when used.
    typedef struct packed {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [POS_W-1:0]   cx;
        logic [POS_W-1:0]   cy;
        logic [RAD_W-1:0]   radius;
        logic [ALPHA_W-1:0] alpha;
        logic [BYTE_W-1:0]  old;
    } t_pixel_txn;

    typedef struct packed {
        logic              written;
        logic [BYTE_W-1:0] new_alpha;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_pixel_result;

    // A directed row. When typed is set, the result is the one written in the
    // row; otherwise it comes from the coverage predictor.
    typedef struct packed {
        t_pixel_txn    txn;
        logic          typed;
        t_pixel_result want;
    } t_dab_row;

    localparam t_pixel_result ANY_RESULT = '0;

    // Every directed row runs with the canvas and colour left by reset: a
    // 1024 by 1024 canvas and a black brush.
    localparam int DIRECTED_N = 23;
    localparam t_dab_row DIRECTED_ROWS [DIRECTED_N] = '{
        // Empty dab at the origin: the box collapses and nothing is written.
        '{'{12'd0, 12'd0, 22'd0, 22'd0, 20'd0, 9'd0, 8'd0},
          1'b1, '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0}},
        // Every field at its top: the box clamps to the canvas and the pixel
        // lies beyond it.
        '{'{12'd4095, 12'd4095, 22'h1FFFFF, 22'h1FFFFF, 20'hFFFFF, 9'd511, 8'd255},
          1'b1, '{1'b0, 8'd255, 8'd0, 8'd0, 8'd0}},
        // Pixel at the dab centre, deep in the interior, opaque dab.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd1280, 9'd256, 8'd0},
          1'b1, '{1'b1, 8'd255, 8'd0, 8'd0, 8'd0}},
        // Opacity above 256 is treated as opaque.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd1280, 9'd511, 8'd0},
          1'b1, '{1'b1, 8'd255, 8'd0, 8'd0, 8'd0}},
        // The stored alpha wins when it is larger than the coverage.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd1280, 9'd100, 8'd200},
          1'b1, '{1'b1, 8'd200, 8'd0, 8'd0, 8'd0}},
        // Zero coverage still counts as a write.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd1280, 9'd0, 8'd7},
          1'b1, '{1'b1, 8'd7, 8'd0, 8'd0, 8'd0}},
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd1280, 9'd254, 8'd0},
          1'b1, '{1'b1, 8'd254, 8'd0, 8'd0, 8'd0}},
        // Zero radius centred on the pixel: the rim gives exactly half.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd0, 9'd256, 8'd0},
          1'b1, '{1'b1, 8'd128, 8'd0, 8'd0, 8'd0}},
        // Rim just inside the outer edge.
        '{'{12'd10, 12'd10, 22'd2561, 22'd2688, 20'd0, 9'd256, 8'd0},
          1'b0, ANY_RESULT},
        // Rim just outside the interior, then the interior boundary itself.
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd127, 9'd256, 8'd0},
          1'b0, ANY_RESULT},
        '{'{12'd10, 12'd10, 22'd2688, 22'd2688, 20'd128, 9'd200, 8'd0},
          1'b0, ANY_RESULT},
        // Diagonal offset with dr at exactly one half, then one step inside.
        '{'{12'd10, 12'd10, 22'd2432, 22'd2432, 20'd234, 9'd256, 8'd9},
          1'b0, ANY_RESULT},
        '{'{12'd10, 12'd10, 22'd2432, 22'd2432, 20'd235, 9'd256, 8'd0},
          1'b0, ANY_RESULT},
        // Most negative centre with the largest radius stays off the canvas.
        '{'{12'd0, 12'd0, 22'h200000, 22'h200000, 20'hFFFFF, 9'd256, 8'd128},
          1'b1, '{1'b0, 8'd128, 8'd0, 8'd0, 8'd0}},
        // A dab covering the whole canvas never reaches the last column or
        // the last row.
        '{'{12'd1023, 12'd500, 22'd131072, 22'd131072, 20'hFFFFF, 9'd256, 8'd3},
          1'b1, '{1'b0, 8'd3, 8'd0, 8'd0, 8'd0}},
        '{'{12'd500, 12'd1023, 22'd131072, 22'd131072, 20'hFFFFF, 9'd256, 8'd4},
          1'b1, '{1'b0, 8'd4, 8'd0, 8'd0, 8'd0}},
        '{'{12'd1022, 12'd1022, 22'd131072, 22'd131072, 20'hFFFFF, 9'd256, 8'd0},
          1'b1, '{1'b1, 8'd255, 8'd0, 8'd0, 8'd0}},
        '{'{12'd0, 12'd0, 22'd131072, 22'd131072, 20'hFFFFF, 9'd256, 8'd0},
          1'b1, '{1'b1, 8'd255, 8'd0, 8'd0, 8'd0}},
        // Pixel beyond the canvas edge.
        '{'{12'd2000, 12'd2000, 22'd131072, 22'd131072, 20'hFFFFF, 9'd256, 8'd77},
          1'b1, '{1'b0, 8'd77, 8'd0, 8'd0, 8'd0}},
        '{'{12'd0, 12'd0, 22'h1FFFFF, 22'h1FFFFF, 20'd0, 9'd256, 8'd0},
          1'b0, ANY_RESULT},
        '{'{12'd512, 12'd512, 22'd0, 22'd0, 20'hFFFFF, 9'd257, 8'd0},
          1'b0, ANY_RESULT},
        '{'{12'd5, 12'd7, 22'd1708, 22'd1720, 20'd400, 9'd180, 8'd50},
          1'b0, ANY_RESULT},
        '{'{12'd4095, 12'd0, 22'd0, 22'd0, 20'd0, 9'd256, 8'd0},
          1'b0, ANY_RESULT}
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [PIX_W-1:0]      i_pixel_col     = '0;
    logic [PIX_W-1:0]      i_pixel_row     = '0;
    logic signed [POS_W-1:0] i_centre_x    = '0;
    logic signed [POS_W-1:0] i_centre_y    = '0;
    logic [RAD_W-1:0]      i_dab_radius    = '0;
    logic [ALPHA_W-1:0]    i_dab_alpha     = '0;
    logic [BYTE_W-1:0]     i_old_alpha     = '0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_valid;
    logic                  o_pixel_written;
    logic [BYTE_W-1:0]     o_new_alpha;
    logic [BYTE_W-1:0]     o_out_red;
    logic [BYTE_W-1:0]     o_out_green;
    logic [BYTE_W-1:0]     o_out_blue;

    // The testbench's own copy of the configuration registers, starting at
    // their reset values. Writes update it as they are driven, ahead of the
    // edge where the block takes them.
    logic [SIDE_REG_W-1:0] cfg_width  = 13'd1024;
    logic [SIDE_REG_W-1:0] cfg_height = 13'd1024;
    logic [BYTE_W-1:0]     cfg_red    = '0;
    logic [BYTE_W-1:0]     cfg_green  = '0;
    logic [BYTE_W-1:0]     cfg_blue   = '0;

    // Expected pixel results, oldest first, one per accepted transaction.
    t_pixel_result pending_pixels [$];
    int mismatch_count = 0;
    int cycle_count    = 0;

    brush_dab_pixel_coverage dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .i_centre_x      (i_centre_x),
        .i_centre_y      (i_centre_y),
        .i_dab_radius    (i_dab_radius),
        .i_dab_alpha     (i_dab_alpha),
        .i_old_alpha     (i_old_alpha),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_pixel_written (o_pixel_written),
        .o_new_alpha     (o_new_alpha),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Effective canvas side: register values below 2 or above the largest
    // supported side are pulled back into range.
    function automatic longint canvas_side(logic [SIDE_REG_W-1:0] reg_v);
        longint s;
        s = reg_v;
        if (s < 2) s = 2;
        if (s > CANVAS_MAX) s = CANVAS_MAX;
        return s;
    endfunction

    // Arithmetic shift right is a floor division for negative values too.
    function automatic longint floor_px(longint v);
        return v >>> FRAC;
    endfunction

    function automatic longint ceil_px(longint v);
        return -((-v) >>> FRAC);
    endfunction

    // Upper box edge. It never exceeds side - 1, so the last column and row
    // of the canvas are never covered.
    function automatic longint box_hi(longint c, longint w);
        if (c <= 0) return 0;
        if (c > w - 2) return w - 1;
        return c;
    endfunction

    function automatic longint box_lo(longint f, longint w);
        if (f < 1) return 0;
        if (f >= w) return w - 1;
        return f;
    endfunction

    // Computes the pixel result for one transaction under the current
    // configuration: box test, truncated distance root, rim or interior
    // coverage, then the max with the stored alpha.
    function automatic t_pixel_result predict_coverage(t_pixel_txn t);
        longint        i, j, cx, cy, r, a, w, h, dx, dy, dr, cov;
        longint unsigned rem, root, bit_v;
        logic          in_box;
        t_pixel_result res;
        i  = t.col;
        j  = t.row;
        cx = $signed(t.cx);
        cy = $signed(t.cy);
        r  = t.radius;
        a  = t.alpha;
        if (a > longint'(ALPHA_OPAQUE)) a = ALPHA_OPAQUE;
        w  = canvas_side(cfg_width);
        h  = canvas_side(cfg_height);
        res = '0;
        cov = 0;
        in_box = (i >= box_lo(floor_px(cx - r), w)) && (i < box_hi(ceil_px(cx + r), w)) &&
                 (j >= box_lo(floor_px(cy - r), h)) && (j < box_hi(ceil_px(cy + r), h));
        if (in_box) begin
            dx = (i << FRAC) + HALF - cx;
            dy = (j << FRAC) + HALF - cy;
            rem = dx * dx + dy * dy;
            // Bit-by-bit integer square root, truncating.
            root = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > rem) bit_v >>= 2;
            while (bit_v != 0) begin
                if (rem >= root + bit_v) begin
                    rem  = rem - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end else begin
                    root = root >> 1;
                end
                bit_v >>= 2;
            end
            dr = longint'(root) - r;
            if (dr < HALF) begin
                res.written = 1'b1;
                cov = (dr > -HALF) ? ((a * (HALF - dr)) >>> FRAC) : a;
                if (cov > longint'(BYTE_MAX)) cov = BYTE_MAX;
            end
        end
        res.new_alpha = (res.written && cov > longint'(t.old)) ? cov[BYTE_W-1:0] : t.old;
        if (res.written) begin
            res.red   = cfg_red;
            res.green = cfg_green;
            res.blue  = cfg_blue;
        end
        return res;
    endfunction

    // Random pixel transaction. Most place a modest dab around a pixel that
    // lies on the canvas, with the centre offset so that the pixel lands in
    // the interior, on the soft rim or just outside it. A tenth are full-range
    // noise in position and radius; another tenth use radii up to the maximum.
    function automatic t_pixel_txn random_dab_item();
        t_pixel_txn t;
        longint     w, h, px, py, r, reach, cx, cy;
        int         kind;
        w = canvas_side(cfg_width);
        h = canvas_side(cfg_height);
        kind = $urandom_range(0, 9);
        t.alpha = ($urandom_range(0, 3) == 0) ? ALPHA_W'($urandom) :
                                                ALPHA_W'($urandom_range(0, 256));
        t.old = BYTE_W'($urandom);
        if (kind == 0) begin
            t.col    = PIX_W'($urandom);
            t.row    = PIX_W'($urandom);
            t.cx     = POS_W'($urandom);
            t.cy     = POS_W'($urandom);
            t.radius = RAD_W'($urandom);
        end else begin
            px = $urandom_range(0, int'(w - 1));
            py = $urandom_range(0, int'(h - 1));
            if (kind == 1) begin
                r = $urandom_range(0, 1048575);
            end else if (kind <= 3) begin
                r = $urandom_range(0, 64 << FRAC);
            end else begin
                r = $urandom_range(0, 6 << FRAC);
            end
            reach = r + (2 << FRAC);
            cx = (px << FRAC) + HALF + longint'($urandom_range(0, int'(2 * reach))) - reach;
            cy = (py << FRAC) + HALF + longint'($urandom_range(0, int'(2 * reach))) - reach;
            t.col    = px[PIX_W-1:0];
            t.row    = py[PIX_W-1:0];
            t.cx     = cx[POS_W-1:0];
            t.cy     = cy[POS_W-1:0];
            t.radius = r[RAD_W-1:0];
        end
        return t;
    endfunction

    // Presents one transaction after an idle gap and records its expected
    // result at the accepting edge. Start stays high across back-to-back
    // transactions; it is only lowered when a gap follows.
    task automatic issue_pixel(t_pixel_txn t, logic typed, t_pixel_result want, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_pixel_col  <= t.col;
        i_pixel_row  <= t.row;
        i_centre_x   <= t.cx;
        i_centre_y   <= t.cy;
        i_dab_radius <= t.radius;
        i_dab_alpha  <= t.alpha;
        i_old_alpha  <= t.old;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(typed ? want : predict_coverage(t));
    endtask

    // One register write. The write enable stays high when writes follow one
    // another; the caller lowers it after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CANVAS_WIDTH:  cfg_width  = data;
            CFG_CANVAS_HEIGHT: cfg_height = data;
            CFG_BRUSH_RED:     cfg_red    = data[BYTE_W-1:0];
            CFG_BRUSH_GREEN:   cfg_green  = data[BYTE_W-1:0];
            CFG_BRUSH_BLUE:    cfg_blue   = data[BYTE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One phase: let the pipeline empty, program canvas and colour, then run
    // a batch of random transactions. Every transaction yields a result, so
    // an empty expectation queue means nothing is left in flight.
    task automatic run_phase(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                             logic [CFG_DATA_W-1:0] red, logic [CFG_DATA_W-1:0] green,
                             logic [CFG_DATA_W-1:0] blue, int n_items, bit no_idle);
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        write_reg(CFG_CANVAS_WIDTH, w);
        write_reg(CFG_CANVAS_HEIGHT, h);
        write_reg(CFG_BRUSH_RED, red);
        write_reg(CFG_BRUSH_GREEN, green);
        write_reg(CFG_BRUSH_BLUE, blue);
        write_reg(CFG_UNUSED_TOP, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        repeat (n_items) begin
            issue_pixel(random_dab_item(), 1'b0, ANY_RESULT,
                        no_idle ? 0 : $urandom_range(0, 10));
        end
    endtask

    // Result checker. Outputs are sampled at the edge that ends the strobe
    // cycle, before the block updates them, so there is no ordering race.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_written !== want.written) begin
                    $error("pixel_written: expected %0d, actual %0d",
                           want.written, o_pixel_written);
                    mismatch_count++;
                end
                if (o_new_alpha !== want.new_alpha) begin
                    $error("new_alpha: expected %0d, actual %0d", want.new_alpha, o_new_alpha);
                    mismatch_count++;
                end
                if (o_out_red !== want.red) begin
                    $error("out_red: expected %0d, actual %0d", want.red, o_out_red);
                    mismatch_count++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green: expected %0d, actual %0d", want.green, o_out_green);
                    mismatch_count++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue: expected %0d, actual %0d", want.blue, o_out_blue);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset configuration.
        foreach (DIRECTED_ROWS[k]) begin
            issue_pixel(DIRECTED_ROWS[k].txn, DIRECTED_ROWS[k].typed,
                        DIRECTED_ROWS[k].want, $urandom_range(0, 10));
        end

        // Smallest canvas with white brush, then the largest with black and
        // no idle cycles, then out-of-range sides that must be pulled back.
        run_phase(13'd2, 13'd2, 13'h1FFF, 13'h1FFF, 13'h1FFF, 100, 1'b0);
        run_phase(13'd4096, 13'd4096, 13'd0, 13'd0, 13'd0, 110, 1'b1);
        run_phase(13'd0, 13'd1, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), 100, 1'b0);
        run_phase(13'h1FFF, 13'd4097, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), 110, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(2, 4096)), CFG_DATA_W'($urandom_range(2, 4096)),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  110, 1'b1);
        run_phase(13'd3, 13'd4095, 13'h00AA, 13'h0155, 13'h1F00, 110, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(2, 4096)), CFG_DATA_W'($urandom_range(2, 4096)),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  110, 1'b0);

        // Drain: wait for every expected result, then past the pipeline
        // depth to catch any extra strobe.
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
